[src/rotated_ellipse_mask_fill_macros.svh]
// Assertion macros shared by the checker of the rotated ellipse mask fill block.
`ifndef ROTATED_ELLIPSE_MASK_FILL_MACROS_SVH
`define ROTATED_ELLIPSE_MASK_FILL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent (or after an explicit delay).
`define REMF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |-> cons) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define REMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) \
      else $error(msg);

`endif

[src/remf_pkg.sv]
// Types, constants and register codes of the rotated ellipse mask fill block.
package remf_pkg;

   // parameter defaults
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_PIXEL_BITS = 16;

   // register field widths
   localparam int WIDTH_REG_W = 13;
   localparam int CENTER_W    = 17;
   localparam int TRIG_W      = 16;
   localparam int INV_W       = 32;
   localparam int FILL_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // register reset values
   localparam int          RESET_IMAGE_WIDTH = 640;
   localparam int          RESET_COS         = 32767;
   localparam logic [31:0] RESET_INV         = 32'h4000_0000;

   // fixed point
   localparam int POS_FRAC    = 4;      // pixel position Q.4
   localparam int ROUND_BIAS  = 1024;   // half of Q.19 -> Q.8 step
   localparam int ROUND_SHIFT = 11;     // Q.19 -> Q.8
   localparam int FRAC_SHIFT  = 30;     // Q2.30 weight
   localparam int HI_SPLIT    = 32;     // square split into low and high words
   localparam int HI_ALIGN    = 2;      // high word weight: 2^32 >> 30
   localparam int ONE_Q16     = 65536;  // 1.0 in Q.16

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COS_ANGLE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NEG_SIN_ANGLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_MAJOR_SQ  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_MINOR_SQ  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FILL_VALUE    = 3'd7;

   // multiplier operand selection
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_CS_DX,
      MUL_SN_DY,
      MUL_CS_DY,
      MUL_SN_DX,
      MUL_MX_MX,
      MUL_MY_MY,
      MUL_XLO_MAJ,
      MUL_XHI_MAJ,
      MUL_YLO_MIN,
      MUL_YHI_MIN
   } mul_sel_type;

   // what is done with the product of the previous cycle
   typedef enum logic [3:0] {
      POST_NONE,
      POST_ACC_SET,
      POST_XI,
      POST_ETA,
      POST_MXSQ,
      POST_MYSQ,
      POST_SUM_LO_SET,
      POST_SUM_LO_ADD,
      POST_SUM_HI_ADD
   } post_op_type;

   // controller to datapath command
   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      post_op_type post_op;
      logic        out_load;
   } remf_cmd_type;

   // configuration registers
   typedef struct packed {
      logic        [WIDTH_REG_W-1:0] image_width;
      logic signed [CENTER_W-1:0]    center_x;
      logic signed [CENTER_W-1:0]    center_y;
      logic signed [TRIG_W-1:0]      cos_angle;
      logic signed [TRIG_W-1:0]      neg_sin_angle;
      logic        [INV_W-1:0]       inv_major_sq;
      logic        [INV_W-1:0]       inv_minor_sq;
      logic        [FILL_W-1:0]      fill_value;
   } remf_cfg_type;

endpackage

[src/remf_regs.sv]
// Configuration register bank of the rotated ellipse mask fill block.
module remf_regs
   import remf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output remf_cfg_type           cfg
);

   remf_cfg_type cfg_ff;
   remf_cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   cfg_in.image_width   = csr_write_data[WIDTH_REG_W-1:0];
            REG_CENTER_X:      cfg_in.center_x      = csr_write_data[CENTER_W-1:0];
            REG_CENTER_Y:      cfg_in.center_y      = csr_write_data[CENTER_W-1:0];
            REG_COS_ANGLE:     cfg_in.cos_angle     = csr_write_data[TRIG_W-1:0];
            REG_NEG_SIN_ANGLE: cfg_in.neg_sin_angle = csr_write_data[TRIG_W-1:0];
            REG_INV_MAJOR_SQ:  cfg_in.inv_major_sq  = csr_write_data[INV_W-1:0];
            REG_INV_MINOR_SQ:  cfg_in.inv_minor_sq  = csr_write_data[INV_W-1:0];
            REG_FILL_VALUE:    cfg_in.fill_value    = csr_write_data[FILL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= WIDTH_REG_W'(RESET_IMAGE_WIDTH);
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
         cfg_ff.cos_angle     <= TRIG_W'(RESET_COS);
         cfg_ff.neg_sin_angle <= '0;
         cfg_ff.inv_major_sq  <= RESET_INV;
         cfg_ff.inv_minor_sq  <= RESET_INV;
         cfg_ff.fill_value    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/remf_ctrl.sv]
// Sequencer of the rotated ellipse mask fill block: steps the shared multiplier schedule.
module remf_ctrl
   import remf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output remf_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CS_DX   = 4'd1;
   localparam logic [3:0] ST_SN_DY   = 4'd2;
   localparam logic [3:0] ST_CS_DY   = 4'd3;
   localparam logic [3:0] ST_SN_DX   = 4'd4;
   localparam logic [3:0] ST_MX_SQ   = 4'd5;
   localparam logic [3:0] ST_MX_HOLD = 4'd6;
   localparam logic [3:0] ST_MY_SQ   = 4'd7;
   localparam logic [3:0] ST_X_LO    = 4'd8;
   localparam logic [3:0] ST_X_HI    = 4'd9;
   localparam logic [3:0] ST_Y_LO    = 4'd10;
   localparam logic [3:0] ST_Y_HI    = 4'd11;
   localparam logic [3:0] ST_SUM_END = 4'd12;
   localparam logic [3:0] ST_FINISH  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // schedule: a step issues at most one multiply and may retire the previous product
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.mul_sel  = MUL_NONE;
      cmd.post_op  = POST_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) state_in = ST_CS_DX;
         end
         ST_CS_DX: begin
            cmd.mul_sel = MUL_CS_DX;
            state_in    = ST_SN_DY;
         end
         ST_SN_DY: begin
            cmd.mul_sel = MUL_SN_DY;
            cmd.post_op = POST_ACC_SET;
            state_in    = ST_CS_DY;
         end
         ST_CS_DY: begin
            cmd.mul_sel = MUL_CS_DY;
            cmd.post_op = POST_XI;
            state_in    = ST_SN_DX;
         end
         ST_SN_DX: begin
            cmd.mul_sel = MUL_SN_DX;
            cmd.post_op = POST_ACC_SET;
            state_in    = ST_MX_SQ;
         end
         ST_MX_SQ: begin
            cmd.mul_sel = MUL_MX_MX;
            cmd.post_op = POST_ETA;
            state_in    = ST_MX_HOLD;
         end
         ST_MX_HOLD: begin
            cmd.post_op = POST_MXSQ;
            state_in    = ST_MY_SQ;
         end
         ST_MY_SQ: begin
            cmd.mul_sel = MUL_MY_MY;
            state_in    = ST_X_LO;
         end
         ST_X_LO: begin
            cmd.mul_sel = MUL_XLO_MAJ;
            cmd.post_op = POST_MYSQ;
            state_in    = ST_X_HI;
         end
         ST_X_HI: begin
            cmd.mul_sel = MUL_XHI_MAJ;
            cmd.post_op = POST_SUM_LO_SET;
            state_in    = ST_Y_LO;
         end
         ST_Y_LO: begin
            cmd.mul_sel = MUL_YLO_MIN;
            cmd.post_op = POST_SUM_HI_ADD;
            state_in    = ST_Y_HI;
         end
         ST_Y_HI: begin
            cmd.mul_sel = MUL_YHI_MIN;
            cmd.post_op = POST_SUM_LO_ADD;
            state_in    = ST_SUM_END;
         end
         ST_SUM_END: begin
            cmd.post_op = POST_SUM_HI_ADD;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // wait here while the output register holds an untaken item
            cmd.out_load = slot_free;
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/remf_datapath.sv]
// Datapath of the rotated ellipse mask fill block: counters, shared multiplier, test, output.
module remf_datapath
   import remf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  remf_cmd_type          cmd,
   input  remf_cfg_type          cfg,
   input  logic [PIXEL_BITS-1:0] req_pixel_in,
   input  logic                  req_last_of_frame,
   output logic [PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                  rsp_inside_res,
   output logic                  rsp_frame_end
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int PW    = ((CW > RW) ? CW : RW) + POS_FRAC;
   localparam int DW    = (((PW + 1) > CENTER_W) ? (PW + 1) : CENTER_W) + 1;
   localparam int XW    = TRIG_W + DW + 1;
   localparam int MW    = XW - ROUND_SHIFT;
   localparam int SQW   = 2 * MW;
   localparam int HW    = SQW - HI_SPLIT;
   localparam int SUMW  = SQW + HI_ALIGN + 1;
   localparam int MUL_A = (DW > (MW + 1)) ? DW : (MW + 1);
   localparam int MUL_B = (MUL_A > (HW + 1)) ? MUL_A : (HW + 1);
   localparam int MUL_W = (MUL_B > (INV_W + 1)) ? MUL_B : (INV_W + 1);
   localparam int PRW   = 2 * MUL_W;
   localparam int CMPW  = ((WIDTH_REG_W > CW) ? WIDTH_REG_W : CW) + 1;

   // pixel position counters
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CMPW-1:0] width_reg, width_max, width_eff, col_next;
   logic [RW:0]     row_next;

   // item registers
   logic signed [DW-1:0]    dx_ff, dy_ff;
   logic [PIXEL_BITS-1:0]   pix_ff;
   logic                    last_ff;

   // arithmetic registers
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PRW-1:0]   prod_ff;
   logic signed [XW-1:0]    acc_ff, xi_ff, eta_ff;
   logic [MW-1:0]           mx_ff, my_ff;
   logic [SQW-1:0]          mxsq_ff, mysq_ff;
   logic [SUMW-1:0]         sum_ff, lo_term, hi_term;

   // output register
   logic [PIXEL_BITS-1:0]   pix_out_ff;
   logic                    inside_ff;
   logic                    frame_end_ff;
   logic                    in_ellipse;

   // |v| rounded from Q.19 to Q.8, halves away from zero
   function automatic logic [MW-1:0] round_mag(input logic signed [XW-1:0] v);
      logic [XW:0] biased;
      if (v[XW-1]) biased = {1'b0, ~v} + (XW+1)'(ROUND_BIAS + 1);
      else biased = {1'b0, v} + (XW+1)'(ROUND_BIAS);
      return MW'(biased >> ROUND_SHIFT);
   endfunction

   // effective row width: zero acts as one, clamped to the maximum
   assign width_reg = CMPW'(cfg.image_width);
   assign width_max = CMPW'(MAX_WIDTH);
   assign width_eff = (width_reg == '0) ? CMPW'(1) :
                      ((width_reg > width_max) ? width_max : width_reg);
   assign col_next  = CMPW'(col_ff) + CMPW'(1);
   assign row_next  = (RW+1)'(row_ff) + (RW+1)'(1);

   // counter advance on each accepted item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.capture) begin
         priority if (req_last_of_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width_eff) begin
            col_in = '0;
            if (row_next < (RW+1)'(MAX_HEIGHT)) row_in = row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // capture the item and its offset from the centre
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dx_ff   <= DW'($signed({1'b0, col_ff, {POS_FRAC{1'b0}}})) - DW'($signed(cfg.center_x));
         dy_ff   <= DW'($signed({1'b0, row_ff, {POS_FRAC{1'b0}}})) - DW'($signed(cfg.center_y));
         pix_ff  <= req_pixel_in;
         last_ff <= req_last_of_frame;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_CS_DX: begin
            mul_a = MUL_W'($signed(cfg.cos_angle));
            mul_b = MUL_W'(dx_ff);
         end
         MUL_SN_DY: begin
            mul_a = MUL_W'($signed(cfg.neg_sin_angle));
            mul_b = MUL_W'(dy_ff);
         end
         MUL_CS_DY: begin
            mul_a = MUL_W'($signed(cfg.cos_angle));
            mul_b = MUL_W'(dy_ff);
         end
         MUL_SN_DX: begin
            mul_a = MUL_W'($signed(cfg.neg_sin_angle));
            mul_b = MUL_W'(dx_ff);
         end
         MUL_MX_MX: begin
            mul_a = MUL_W'({1'b0, mx_ff});
            mul_b = MUL_W'({1'b0, mx_ff});
         end
         MUL_MY_MY: begin
            mul_a = MUL_W'({1'b0, my_ff});
            mul_b = MUL_W'({1'b0, my_ff});
         end
         MUL_XLO_MAJ: begin
            mul_a = MUL_W'({1'b0, mxsq_ff[HI_SPLIT-1:0]});
            mul_b = MUL_W'({1'b0, cfg.inv_major_sq});
         end
         MUL_XHI_MAJ: begin
            mul_a = MUL_W'({1'b0, mxsq_ff[SQW-1:HI_SPLIT]});
            mul_b = MUL_W'({1'b0, cfg.inv_major_sq});
         end
         MUL_YLO_MIN: begin
            mul_a = MUL_W'({1'b0, mysq_ff[HI_SPLIT-1:0]});
            mul_b = MUL_W'({1'b0, cfg.inv_minor_sq});
         end
         MUL_YHI_MIN: begin
            mul_a = MUL_W'({1'b0, mysq_ff[SQW-1:HI_SPLIT]});
            mul_b = MUL_W'({1'b0, cfg.inv_minor_sq});
         end
         MUL_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // weighted square terms: low word drops 30 fraction bits, high word gains 2
   assign lo_term = SUMW'(prod_ff[PRW-1:FRAC_SHIFT]);
   assign hi_term = SUMW'(prod_ff) << HI_ALIGN;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      // rounded magnitudes follow the rotated coordinates in the next cycle
      mx_ff   <= round_mag(xi_ff);
      my_ff   <= round_mag(eta_ff);
      unique case (cmd.post_op)
         POST_ACC_SET:    acc_ff  <= XW'(prod_ff);
         POST_XI:         xi_ff   <= acc_ff + XW'(prod_ff);
         POST_ETA:        eta_ff  <= acc_ff - XW'(prod_ff);
         POST_MXSQ:       mxsq_ff <= SQW'(prod_ff);
         POST_MYSQ:       mysq_ff <= SQW'(prod_ff);
         POST_SUM_LO_SET: sum_ff  <= lo_term;
         POST_SUM_LO_ADD: sum_ff  <= sum_ff + lo_term;
         POST_SUM_HI_ADD: sum_ff  <= sum_ff + hi_term;
         POST_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // inside test and output register
   assign in_ellipse = (sum_ff <= SUMW'(ONE_Q16));

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pix_out_ff   <= in_ellipse ? PIXEL_BITS'(cfg.fill_value) : pix_ff;
         inside_ff    <= in_ellipse;
         frame_end_ff <= last_ff;
      end
   end

   assign rsp_pixel_out  = pix_out_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule

[src/rotated_ellipse_mask_fill.sv]
// Rotated ellipse mask fill: top level joining register bank, sequencer and datapath.
//
// Pixels enter in raster order on the req_ channel (req_pixel_in, req_last_of_frame) and
// leave on the rsp_ channel (rsp_pixel_out, rsp_inside_res, rsp_frame_end), one result
// item per input item, in order. An item moves when valid is high and stall is low.
// Column and row counters follow the stream; a pixel inside or on the rotated ellipse
// is replaced by the fill value, all others pass through.
// Each item runs through a 12-step schedule on one shared 33x33 signed multiplier
// (rotation products, rounded squares, Q2.30 weighting split in low and high words),
// then a finish step loads the output register. A new item is accepted only once the
// previous item has left the finish step. The input can be accepted while a finished item
// still waits in the output register; a stalled receiver holds the next result in the
// finish step and keeps req_stall high until the output register frees up.
// Reset (synchronous) empties the block, clears the counters and loads the register
// defaults. Configuration writes via csr_ are taken at once and belong in idle time.
module rotated_ellipse_mask_fill
   import remf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_BITS-1:0]  req_pixel_in,
   input  logic                   req_last_of_frame,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_BITS-1:0]  rsp_pixel_out,
   output logic                   rsp_inside_res,
   output logic                   rsp_frame_end,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   remf_cfg_type cfg;
   remf_cmd_type cmd;

   remf_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   remf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   remf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_pixel_in      (req_pixel_in),
      .req_last_of_frame (req_last_of_frame),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

[src/remf_checker.sv]
// Port-level checker of the rotated ellipse mask fill block and its bind.
`include "rotated_ellipse_mask_fill_macros.svh"

module remf_checker
   import remf_pkg::*;
#(
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PIXEL_BITS-1:0] rsp_pixel_out,
   input logic                  rsp_inside_res,
   input logic                  rsp_frame_end
);

   logic accept;
   assign accept = req_valid && !req_stall;

   // one item at a time: input closes right after an accept
   `REMF_ASSERT_NEXT(a_busy_after_accept, accept, req_stall, "input open after accept")

   // input is still closed when the schedule reaches the finish step
   `REMF_ASSERT_IMPL(a_busy_to_finish, accept, ##13 req_stall, "input reopened early")

   // a result is on the output once the schedule has run
   `REMF_ASSERT_IMPL(a_result_ready, accept, ##14 rsp_valid, "no result after schedule")

   // a stalled result item holds
   `REMF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_inside_res) && $stable(rsp_frame_end), "stalled result changed")

endmodule

bind rotated_ellipse_mask_fill remf_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_out  (rsp_pixel_out),
   .rsp_inside_res (rsp_inside_res),
   .rsp_frame_end  (rsp_frame_end)
);
